/* rtl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared widths, register map, controller states and the command and status
// bundles that pass between the clock replacement controller and datapath.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int PAGE_W     = 16;
  localparam int FRAME_W    = 3;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic       CFG_IDX_FRAMES = 1'b0;
  localparam logic [3:0] FRAMES_RESET   = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } cpr_state_t;

  typedef struct packed {
    logic load_page;
    logic start_sweep;
    logic sweep_step;
    logic commit_hit;
    logic commit_fill;
    logic commit_repl;
  } cpr_cmd_t;

  typedef struct packed {
    logic hit;
    logic free_found;
    logic ref_set;
  } cpr_sts_t;

endpackage

/* rtl/cpr_if.sv */
// ----------------------------------------------------------------------------
// cpr_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface cpr_in_if;
  import cpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_out_if;
  import cpr_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic               fault;
  logic [FRAME_W-1:0] frame_index;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output fault, output frame_index,
                  output evicted_valid, output evicted_page, output fault_count,
                  input ready);
  modport sink   (input valid, input hit, input fault, input frame_index,
                  input evicted_valid, input evicted_page, input fault_count,
                  output ready);
endinterface

/* rtl/cpr_dp.sv */
// ----------------------------------------------------------------------------
// cpr_dp
// Frame store, valid and reference bits, clock hand, sweep pointer, fault
// counter and result register of the clock replacement unit.
// ----------------------------------------------------------------------------
module cpr_dp #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cpr_pkg::CFG_W-1:0]     frames_in_use,
  input  logic [cpr_pkg::PAGE_W-1:0]    in_page,
  input  cpr_pkg::cpr_cmd_t             cmd,
  output cpr_pkg::cpr_sts_t             sts,
  output logic                          res_hit,
  output logic                          res_fault,
  output logic [cpr_pkg::FRAME_W-1:0]   res_frame,
  output logic                          res_evicted_valid,
  output logic [cpr_pkg::PAGE_W-1:0]    res_evicted_page,
  output logic [cpr_pkg::COUNT_W-1:0]   res_fault_count
);
  import cpr_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] frame_page_r [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r, frame_valid_nxt;
  logic [FRAMES-1:0]    ref_bit_r, ref_bit_nxt;
  logic [FIDX_W-1:0]    hand_r, hand_nxt;
  logic [FIDX_W-1:0]    sweep_r, sweep_nxt;
  logic [COUNT_W-1:0]   fault_total_r, fault_total_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;

  logic                 out_hit_r, out_hit_nxt;
  logic                 out_fault_r, out_fault_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic                 out_ev_r, out_ev_nxt;
  logic [PAGE_W-1:0]    out_evp_r, out_evp_nxt;
  logic [COUNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0]     n_act;
  logic [FIDX_W-1:0]    hand_norm;
  logic                 hit_found, free_found;
  logic [FIDX_W-1:0]    hit_idx, free_idx;
  logic [COUNT_W-1:0]   fault_total_inc;

  function automatic logic [FIDX_W-1:0] next_idx(input logic [FIDX_W-1:0] h,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(h) + CNT_W'(1);
    return (inc >= n) ? '0 : FIDX_W'(inc);
  endfunction

  always_comb begin
    if (frames_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use);
    end
  end

  assign hand_norm = (CNT_W'(hand_r) >= n_act) ? '0 : hand_r;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (CNT_W'(i) < n_act) begin
        if (frame_valid_r[i] && (frame_page_r[i] == page_r)) begin
          hit_found = 1'b1;
          hit_idx   = FIDX_W'(i);
        end
        if (!frame_valid_r[i]) begin
          free_found = 1'b1;
          free_idx   = FIDX_W'(i);
        end
      end
    end
  end

  assign sts.hit        = hit_found;
  assign sts.free_found = free_found;
  assign sts.ref_set    = ref_bit_r[sweep_r];

  assign fault_total_inc = (fault_total_r == '1) ? fault_total_r
                                                 : fault_total_r + COUNT_W'(1);

  always_comb begin
    frame_valid_nxt = frame_valid_r;
    ref_bit_nxt     = ref_bit_r;
    hand_nxt        = hand_r;
    sweep_nxt       = sweep_r;
    fault_total_nxt = fault_total_r;
    page_nxt        = page_r;
    out_hit_nxt     = out_hit_r;
    out_fault_nxt   = out_fault_r;
    out_frame_nxt   = out_frame_r;
    out_ev_nxt      = out_ev_r;
    out_evp_nxt     = out_evp_r;
    out_cnt_nxt     = out_cnt_r;

    if (cmd.load_page) begin
      page_nxt = PAGE_BITS'(in_page);
    end
    if (cmd.start_sweep) begin
      sweep_nxt = hand_norm;
    end
    if (cmd.sweep_step) begin
      ref_bit_nxt[sweep_r] = 1'b0;
      sweep_nxt            = next_idx(sweep_r, n_act);
    end
    if (cmd.commit_hit) begin
      ref_bit_nxt[hit_idx] = 1'b1;
      out_hit_nxt          = 1'b1;
      out_fault_nxt        = 1'b0;
      out_frame_nxt        = FRAME_W'(hit_idx);
      out_ev_nxt           = 1'b0;
      out_evp_nxt          = '0;
      out_cnt_nxt          = fault_total_r;
    end
    if (cmd.commit_fill) begin
      frame_valid_nxt[free_idx] = 1'b1;
      ref_bit_nxt[free_idx]     = 1'b1;
      hand_nxt                  = next_idx(hand_norm, n_act);
      out_hit_nxt               = 1'b0;
      out_fault_nxt             = 1'b0;
      out_frame_nxt             = FRAME_W'(free_idx);
      out_ev_nxt                = 1'b0;
      out_evp_nxt               = '0;
      out_cnt_nxt               = fault_total_r;
    end
    if (cmd.commit_repl) begin
      ref_bit_nxt[sweep_r] = 1'b1;
      hand_nxt             = next_idx(sweep_r, n_act);
      fault_total_nxt      = fault_total_inc;
      out_hit_nxt          = 1'b0;
      out_fault_nxt        = 1'b1;
      out_frame_nxt        = FRAME_W'(sweep_r);
      out_ev_nxt           = 1'b1;
      out_evp_nxt          = PAGE_W'(frame_page_r[sweep_r]);
      out_cnt_nxt          = fault_total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_fill) begin
      frame_page_r[free_idx] <= page_r;
    end
    if (cmd.commit_repl) begin
      frame_page_r[sweep_r] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      ref_bit_r     <= '0;
      hand_r        <= '0;
      sweep_r       <= '0;
      fault_total_r <= '0;
    end else begin
      frame_valid_r <= frame_valid_nxt;
      ref_bit_r     <= ref_bit_nxt;
      hand_r        <= hand_nxt;
      sweep_r       <= sweep_nxt;
      fault_total_r <= fault_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    out_hit_r   <= out_hit_nxt;
    out_fault_r <= out_fault_nxt;
    out_frame_r <= out_frame_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evp_r   <= out_evp_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign res_hit           = out_hit_r;
  assign res_fault         = out_fault_r;
  assign res_frame         = out_frame_r;
  assign res_evicted_valid = out_ev_r;
  assign res_evicted_page  = out_evp_r;
  assign res_fault_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_valid_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(frame_valid_r) & ~frame_valid_r) == '0))
    else $error("frame valid bit cleared while running");

  a_fault_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fault_total_r >= $past(fault_total_r)))
    else $error("fault total decreased");

  a_fill_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_fill |-> free_found)
    else $error("fill committed with no free frame");
`endif

endmodule

/* rtl/cpr_ctrl.sv */
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer for one reference: accept, look up, sweep the clock hand on a
// full miss, and commit the result into the output register.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cpr_pkg::cpr_sts_t sts,
  output cpr_pkg::cpr_cmd_t cmd
);
  import cpr_pkg::*;

  cpr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       commit;

  assign out_free = !out_valid_r || out_ready;
  assign commit   = cmd.commit_hit || cmd.commit_fill || cmd.commit_repl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_page = 1'b1;
          state_nxt     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.hit) begin
          if (out_free) begin
            cmd.commit_hit = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (sts.free_found) begin
          if (out_free) begin
            cmd.commit_fill = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.start_sweep = 1'b1;
          state_nxt       = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.ref_set) begin
          cmd.sweep_step = 1'b1;
        end else if (out_free) begin
          cmd.commit_repl = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !commit)
    else $error("result register overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  a_sweep_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sts.ref_set) |=> (state_r == ST_SWEEP))
    else $error("sweep left while a reference bit was still set");
`endif

endmodule

/* rtl/clock_page_replacement_unit.sv */
// Sequence: a reference is accepted in idle and looked up; a hit or a
//   free-frame fill is then committed to the result register. On a replacement
//   the hand first clears the set reference bits it passes until it finds a victim.
// A new reference is accepted only once the previous one is committed; the
//   sweep visits one frame per cycle, and a commit waits while the result stalls.
// Reset: synchronous, active low; clears valid and reference bits, hand,
//   fault count and result valid, sets frames_in_use to 8; page store is kept.
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Clock (second-chance) page replacement with an APB register for the number
// of frames in use.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cpr_in_if.sink                           in_ch,
  cpr_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cpr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cpr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import cpr_pkg::*;

  logic [CFG_W-1:0] frames_in_use_r, frames_in_use_nxt;
  logic             cfg_wr;
  logic             cfg_sel_frames;
  cpr_cmd_t         cmd;
  cpr_sts_t         sts;
  logic             in_ready;
  logic             out_valid;

  assign pready         = 1'b1;
  assign cfg_sel_frames = (paddr[CFG_ADDR_W-1] == CFG_IDX_FRAMES);
  assign cfg_wr         = psel && penable && pwrite && pready && cfg_sel_frames;
  assign frames_in_use_nxt = cfg_wr ? pwdata[CFG_W-1:0] : frames_in_use_r;
  assign prdata         = cfg_sel_frames ? CFG_DATA_W'(frames_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_RESET;
    end else begin
      frames_in_use_r <= frames_in_use_nxt;
    end
  end

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .frames_in_use     (frames_in_use_r),
    .in_page           (in_ch.page_number),
    .cmd               (cmd),
    .sts               (sts),
    .res_hit           (out_ch.hit),
    .res_fault         (out_ch.fault),
    .res_frame         (out_ch.frame_index),
    .res_evicted_valid (out_ch.evicted_valid),
    .res_evicted_page  (out_ch.evicted_page),
    .res_fault_count   (out_ch.fault_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

/* tb/tb_clock_page_replacement_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_page_replacement_unit
// Drives page references through the clock replacement unit and checks every
// result against an in-bench second-chance predictor. Directed cases cover
// fills, full sweeps, free fills behind an offset hand and out-of-range frame
// counts. Random phases cover many frame counts under random idling, and a
// final run churns a single frame back to back before widening again.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_unit;
  import cpr_pkg::*;

  localparam int NUM_FRAMES   = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 165;
  localparam logic [CFG_ADDR_W-1:0] FRAMES_ADDR = CFG_ADDR_W'(4 * CFG_IDX_FRAMES);

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN,
    RX_STARVE
  } rx_mode_t;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
  } page_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cpr_in_if  in_ch ();
  cpr_out_if out_ch ();

  clock_page_replacement_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
  bit                 frame_used [NUM_FRAMES];
  bit                 second_chance [NUM_FRAMES];
  int                 hand_pos;
  logic [COUNT_W-1:0] fault_total;
  logic [CFG_W-1:0]   frames_cfg;

  page_result_t pending_results [$];
  int           error_count;

  bit       tx_gaps_on;
  bit       rx_stall_on;
  int       burst_left;
  int       rx_left;
  rx_mode_t rx_mode;
  logic [7:0] rx_pattern;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] pg);
    page_result_t r;
    int  n;
    int  h;
    int  f;
    bit  found;
    bit  free_found;
    bit  stop;
    r = '0;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
    h = (hand_pos >= n) ? 0 : hand_pos;
    found = 1'b0;
    f = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_used[i] && frame_page[i] == pg) begin
        found = 1'b1;
        f = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      second_chance[f] = 1'b1;
    end else begin
      free_found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!free_found && !frame_used[i]) begin
          free_found = 1'b1;
          f = i;
        end
      end
      if (free_found) begin
        frame_page[f]    = pg;
        frame_used[f]    = 1'b1;
        second_chance[f] = 1'b1;
        hand_pos = (h + 1 >= n) ? 0 : h + 1;
      end else begin
        stop = 1'b0;
        for (int k = 0; k < n; k++) begin
          if (!stop) begin
            if (!second_chance[h]) stop = 1'b1;
            else begin
              second_chance[h] = 1'b0;
              h = (h + 1 >= n) ? 0 : h + 1;
            end
          end
        end
        f = h;
        r.fault         = 1'b1;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[f];
        frame_page[f]    = pg;
        second_chance[f] = 1'b1;
        hand_pos = (h + 1 >= n) ? 0 : h + 1;
        if (fault_total != '1) fault_total++;
      end
    end
    r.frame_index = f[FRAME_W-1:0];
    r.fault_count = fault_total;
    return r;
  endfunction

  task automatic check_result();
    page_result_t want;
    if (pending_results.size() == 0) begin
      report_error("result with no reference outstanding");
    end else begin
      want = pending_results.pop_front();
      if (out_ch.hit !== want.hit)
        report_error($sformatf("hit: expected %0h, got %0h", want.hit, out_ch.hit));
      if (out_ch.fault !== want.fault)
        report_error($sformatf("fault: expected %0h, got %0h", want.fault, out_ch.fault));
      if (out_ch.frame_index !== want.frame_index)
        report_error($sformatf("frame_index: expected %0d, got %0d",
                               want.frame_index, out_ch.frame_index));
      if (out_ch.evicted_valid !== want.evicted_valid)
        report_error($sformatf("evicted_valid: expected %0h, got %0h",
                               want.evicted_valid, out_ch.evicted_valid));
      if (out_ch.evicted_page !== want.evicted_page)
        report_error($sformatf("evicted_page: expected %h, got %h",
                               want.evicted_page, out_ch.evicted_page));
      if (out_ch.fault_count !== want.fault_count)
        report_error($sformatf("fault_count: expected %0d, got %0d",
                               want.fault_count, out_ch.fault_count));
    end
  endtask

  // Track transactions on both channels and register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_page[i]) begin
        frame_page[i]    = '0;
        frame_used[i]    = 1'b0;
        second_chance[i] = 1'b0;
      end
      hand_pos    = 0;
      fault_total = '0;
      frames_cfg  = FRAMES_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(predict_reference(in_ch.page_number));
      if (psel && penable && pwrite && pready && paddr == FRAMES_ADDR)
        frames_cfg = pwdata[CFG_W-1:0];
    end
  end

  // Result stall pattern
  always @(posedge clk) begin
    if (rx_left <= 0) begin
      rx_left    = $urandom_range(32, 200);
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = 8'($urandom);
    end
    rx_left--;
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    if (!rx_stall_on) out_ch.ready <= 1'b1;
    else begin
      case (rx_mode)
        RX_FREE:    out_ch.ready <= 1'b1;
        RX_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_ch.ready <= rx_pattern[0];
        default:    out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    int gap;
    if (tx_gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= pg;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FRAMES_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_frames_reg(input logic [CFG_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(want))
      report_error($sformatf("frames_in_use readback: expected %0d, got %0h", want, rd));
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] val);
    logic [CFG_DATA_W-1:0] rd;
    logic [CFG_DATA_W-1:0] wd;
    wait_idle();
    wd = $urandom;
    wd[CFG_W-1:0] = val;
    apb_access(1'b1, wd, rd);
    check_frames_reg(val);
  endtask

  task automatic test_register_readback();
    check_frames_reg(FRAMES_RESET);
    for (int v = 0; v < 16; v++) set_frames(v[CFG_W-1:0]);
  endtask

  task automatic test_free_fill_offset();
    set_frames(4'd2);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    set_frames(4'd8);
    send_page(16'hAAAA);
    send_page(16'h0001);
    send_page(16'h8000);
    send_page(16'h1234);
    send_page(16'hFEDC);
    send_page(16'h7F7F);
  endtask

  task automatic test_second_chance();
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h3333);
    send_page(16'hAAAA);
    send_page(16'h4444);
  endtask

  task automatic test_count_out_of_range();
    set_frames(4'd0);
    send_page(16'h2222);
    send_page(16'h2222);
    set_frames(4'd15);
    send_page(16'hAAAA);
    send_page(16'h1111);
    set_frames(4'd3);
    send_page(16'h6666);
    send_page(16'hFEDC);
  endtask

  task automatic test_random_references();
    logic [CFG_W-1:0]  settings [11] = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd5, 4'd15, 4'd2,
                                         4'd7, 4'd4, 4'd6, 4'd8};
    logic [PAGE_W-1:0] pool [16];
    logic [PAGE_W-1:0] pg;
    int                eff;
    int                span;
    foreach (pool[i]) pool[i] = PAGE_W'($urandom);
    foreach (settings[s]) begin
      set_frames(settings[s]);
      for (int i = 0; i < 8; i++) pool[$urandom_range(0, 15)] = PAGE_W'($urandom);
      eff = (settings[s] == 0) ? 1 : (settings[s] > NUM_FRAMES) ? NUM_FRAMES : settings[s];
      span = eff + $urandom_range(0, 4);
      if (span > 16) span = 16;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) == 0) pg = PAGE_W'($urandom);
        else pg = pool[$urandom_range(0, span - 1)];
        send_page(pg);
      end
    end
  endtask

  task automatic test_single_frame_churn();
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] pool [6];
    set_frames(4'd1);
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    pg = PAGE_W'($urandom);
    for (int k = 0; k < 20; k++) begin
      pg = pg + 16'd1;
      send_page(pg);
    end
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    set_frames(4'd8);
    foreach (pool[i]) pool[i] = PAGE_W'($urandom);
    for (int k = 0; k < 40; k++) send_page(pool[$urandom_range(0, 5)]);
  endtask

  initial begin
    error_count = 0;
    burst_left  = 0;
    rx_left     = 0;
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.page_number <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_readback();
    test_free_fill_offset();
    test_second_chance();
    test_count_out_of_range();
    test_random_references();
    test_single_frame_churn();
    wait_idle();
    if (error_count == 0) begin
      $display("** clock_page_replacement_unit: PASSED **");
    end else begin
      $display("** clock_page_replacement_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[%0t] ERROR: timeout with %0d results outstanding", $time,
             pending_results.size());
    $display("** clock_page_replacement_unit: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
rtl/cpr_pkg.sv
rtl/cpr_if.sv
rtl/cpr_dp.sv
rtl/cpr_ctrl.sv
rtl/clock_page_replacement_unit.sv
tb/tb_clock_page_replacement_unit.sv
